/* hdl/sbce_pkg.sv */
// Shared types and constants for the segment box clip extent block.
`default_nettype none
package sbce_pkg;
  // Coordinate width in bits, two's complement.
  localparam int COORD_WIDTH = 32;

  // Extreme coordinate values.
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Packet carried from the front end to the clip engine through the queue.
  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] p1;
    logic [2:0][COORD_WIDTH-1:0] p2;
    logic                        first;
    logic                        last;
  } seg_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MIN_X = 3'd0;
  localparam logic [2:0] CFG_MAX_X = 3'd1;
  localparam logic [2:0] CFG_MIN_Y = 3'd2;
  localparam logic [2:0] CFG_MAX_Y = 3'd3;
  localparam logic [2:0] CFG_MIN_Z = 3'd4;
  localparam logic [2:0] CFG_MAX_Z = 3'd5;
endpackage
`default_nettype wire

/* hdl/sbce_fifo.sv */
// Two-entry queue between the segment front end and the clip engine.
`default_nettype none
module sbce_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_valid,
  output logic                      wr_ready,
  input  wire sbce_pkg::seg_t       wr_data,
  output logic                      rd_valid,
  input  wire logic                 rd_ready,
  output sbce_pkg::seg_t            rd_data
);
  import sbce_pkg::*;

  seg_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

/* hdl/sbce_div.sv */
// Iterative restoring divider with round half up: q = round(num / den).
`default_nettype none
module sbce_div #(
  parameter int NUM_W = 66,
  parameter int DEN_W = 33
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] n_r, q_r;
  logic [DEN_W:0]   r_r;
  logic [DEN_W-1:0] d_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, fin_r;
  logic [DEN_W:0]   r_sh;
  logic             ge;

  assign r_sh = {r_r[DEN_W-1:0], n_r[NUM_W-1]};
  assign ge   = (r_sh >= {1'b0, d_r});

  // One quotient bit a cycle, then a rounding step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        fin_r  <= 1'b0;
        n_r    <= num;
        d_r    <= den;
        r_r    <= '0;
        q_r    <= '0;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          r_r   <= ge ? r_sh - {1'b0, d_r} : r_sh;
          q_r   <= {q_r[NUM_W-2:0], ge};
          n_r   <= {n_r[NUM_W-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
        end else begin
          // Round up when twice the remainder reaches the divisor.
          if ({r_r, 1'b0} >= {2'b0, d_r}) quo <= q_r + 1'b1;
          else quo <= q_r;
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/sbce_engine.sv */
// Clip engine: six face clips with a shared multiplier and divider, then extent update.
`default_nettype none
module sbce_engine (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic [5:0][sbce_pkg::COORD_WIDTH-1:0]  box,
  input  wire logic                                   seg_valid,
  output logic                                        seg_ready,
  input  wire sbce_pkg::seg_t                         seg,
  output logic                                        res_valid,
  input  wire logic                                   res_ready,
  output logic [2:0][sbce_pkg::COORD_WIDTH-1:0]       res_low,
  output logic [2:0][sbce_pkg::COORD_WIDTH-1:0]       res_high,
  output logic                                        res_kept
);
  import sbce_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FACE = 3'd1;
  localparam logic [2:0] S_MAG  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_GO   = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_ACC  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam logic [2:0] FACE_LAST = 3'd5;

  logic [2:0]                  st_r;
  logic [2:0]                  face_r;
  logic [1:0]                  ax_r;
  logic                        last_r, kept_r, mv1_r;
  logic signed [2:0][CW-1:0]   a_r, b_r;
  logic [CW-1:0]               n_r;
  logic signed [DW-1:0]        dd_r;
  logic [CW-1:0]               mag_r;
  logic                        neg_r;
  logic [PW-1:0]               prod_r;
  logic [2*CW-1:0]             prod_w;
  logic signed [2:0][CW-1:0]   lo_r, hi_r;
  logic                        flag_r;
  logic                        div_go, div_done;
  logic [PW-1:0]               div_q;

  // Face distances for the current face.
  logic [1:0]            fax;
  logic                  upper;
  logic signed [DW-1:0]  fc, c1, c2, d1, d2;
  always_comb begin
    fax   = face_r[2:1];
    upper = face_r[0];
    fc    = DW'(signed'(box[face_r]));
    c1    = DW'(signed'(a_r[fax]));
    c2    = DW'(signed'(b_r[fax]));
    d1    = upper ? c1 - fc : fc - c1;
    d2    = upper ? c2 - fc : fc - c2;
  end

  // Delta along the current axis from moved point to the other one.
  logic signed [DW-1:0] pa, pb, dl;
  always_comb begin
    pa = mv1_r ? DW'(signed'(a_r[ax_r])) : DW'(signed'(b_r[ax_r]));
    pb = mv1_r ? DW'(signed'(b_r[ax_r])) : DW'(signed'(a_r[ax_r]));
    dl = pb - pa;
  end

  // Both factors are below two to the coordinate width, so one narrow product suffices.
  assign prod_w = mag_r * n_r;

  sbce_div #(.NUM_W(PW), .DEN_W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(prod_r),
    .den(dd_r), .done(div_done), .quo(div_q)
  );

  assign div_go    = (st_r == S_GO);
  assign seg_ready = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);
  assign res_low   = lo_r;
  assign res_high  = hi_r;
  assign res_kept  = flag_r;

  logic signed [DW-1:0] newc;
  assign newc = neg_r ? pa - DW'(div_q) : pa + DW'(div_q);

  // Sequencer over faces and axes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      flag_r <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= COORD_MAX;
        hi_r[i] <= COORD_MIN;
      end
    end else begin
      case (st_r)
        S_IDLE: if (seg_valid) begin
          a_r    <= seg.p1;
          b_r    <= seg.p2;
          last_r <= seg.last;
          face_r <= 3'd0;
          kept_r <= 1'b1;
          if (seg.first) begin
            flag_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              lo_r[i] <= COORD_MAX;
              hi_r[i] <= COORD_MIN;
            end
          end
          st_r <= S_FACE;
        end
        S_FACE: begin
          ax_r <= 2'd0;
          if (d1 > 0 && d2 > 0) begin
            kept_r <= 1'b0;
            st_r   <= S_ACC;
          end else if (d1 > 0 || d2 > 0) begin
            mv1_r <= (d1 > 0);
            n_r   <= (d1 > 0) ? CW'(d1) : CW'(d2);
            dd_r  <= (d1 > 0) ? d1 - d2 : d2 - d1;
            st_r  <= S_MAG;
          end else if (face_r == FACE_LAST) begin
            st_r <= S_ACC;
          end else begin
            face_r <= face_r + 3'd1;
          end
        end
        S_MAG: begin
          // Register the delta magnitude for this axis.
          mag_r <= dl[DW-1] ? CW'(-dl) : CW'(dl);
          neg_r <= dl[DW-1];
          st_r  <= S_MUL;
        end
        S_MUL: begin
          prod_r <= PW'(prod_w);
          st_r   <= S_GO;
        end
        S_GO: st_r <= S_DIV;
        S_DIV: if (div_done) begin
          if (mv1_r) a_r[ax_r] <= newc[CW-1:0];
          else       b_r[ax_r] <= newc[CW-1:0];
          if (ax_r == 2'd2) begin
            if (face_r == FACE_LAST) st_r <= S_ACC;
            else begin
              face_r <= face_r + 3'd1;
              st_r   <= S_FACE;
            end
          end else begin
            ax_r <= ax_r + 2'd1;
            st_r <= S_MAG;
          end
        end
        S_ACC: begin
          // A dropped segment clears the flag, a kept one widens the extent.
          if (!kept_r) flag_r <= 1'b0;
          else begin
            for (int i = 0; i < 3; i++) begin
              if ($signed(a_r[i]) < $signed(lo_r[i])) lo_r[i] <= a_r[i];
              if ($signed(b_r[i]) < $signed(lo_r[i]) && $signed(b_r[i]) < $signed(a_r[i]))
                lo_r[i] <= b_r[i];
              if ($signed(a_r[i]) > $signed(hi_r[i])) hi_r[i] <= a_r[i];
              if ($signed(b_r[i]) > $signed(hi_r[i]) && $signed(b_r[i]) > $signed(a_r[i]))
                hi_r[i] <= b_r[i];
            end
          end
          st_r <= last_r ? S_OUT : S_IDLE;
        end
        S_OUT: if (res_ready) begin
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hdl/segment_box_clip_extent.sv */
// Top level of the segment box clip extent block.
// Segments in signed Q16.16 are clipped against an axis-aligned box held in six
// configuration registers (index 0 to 5: x min, x max, y min, y max, z min, z max),
// face by face in that order, and the surviving endpoints widen a running extent.
// A segment marked first empties the extent and sets the all-kept flag; a segment
// marked last sends the extent and the flag as one result transaction. A two-entry
// queue lets the front end take transactions while the clip engine works on one
// segment at a time. In the engine each face that a segment crosses has the moved
// endpoint interpolated on all three axes in turn (magnitude, product, divider
// start, 66 quotient bits, a rounding step and the hand-back); a segment wholly
// beyond a face is dropped there. The result is held until out_ready takes it.
// Configuration is to be written only while no segment is in flight.
`default_nettype none
module segment_box_clip_extent (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [2:0]                              cfg_index,
  input  wire logic signed [sbce_pkg::COORD_WIDTH-1:0] cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic signed [sbce_pkg::COORD_WIDTH-1:0] in_start_x,
  input  wire logic signed [sbce_pkg::COORD_WIDTH-1:0] in_start_y,
  input  wire logic signed [sbce_pkg::COORD_WIDTH-1:0] in_start_z,
  input  wire logic signed [sbce_pkg::COORD_WIDTH-1:0] in_end_x,
  input  wire logic signed [sbce_pkg::COORD_WIDTH-1:0] in_end_y,
  input  wire logic signed [sbce_pkg::COORD_WIDTH-1:0] in_end_z,
  input  wire logic                                    in_first_segment,
  input  wire logic                                    in_last_segment,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [sbce_pkg::COORD_WIDTH-1:0]      out_low_x,
  output logic signed [sbce_pkg::COORD_WIDTH-1:0]      out_low_y,
  output logic signed [sbce_pkg::COORD_WIDTH-1:0]      out_low_z,
  output logic signed [sbce_pkg::COORD_WIDTH-1:0]      out_high_x,
  output logic signed [sbce_pkg::COORD_WIDTH-1:0]      out_high_y,
  output logic signed [sbce_pkg::COORD_WIDTH-1:0]      out_high_z,
  output logic                                         out_every_segment_kept
);
  import sbce_pkg::*;

  logic [5:0][COORD_WIDTH-1:0] box_r;
  seg_t                        in_seg, q_seg;
  logic                        q_valid, q_ready;
  logic [2:0][COORD_WIDTH-1:0] lo, hi;

  assign cfg_ready = 1'b1;

  // Box registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++)
        box_r[i] <= i[0] ? COORD_MAX : COORD_MIN;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_X, CFG_MAX_X, CFG_MIN_Y, CFG_MAX_Y, CFG_MIN_Z, CFG_MAX_Z:
          box_r[cfg_index] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end packs the transaction into the queue.
  always_comb begin
    in_seg.p1    = {in_start_z, in_start_y, in_start_x};
    in_seg.p2    = {in_end_z, in_end_y, in_end_x};
    in_seg.first = in_first_segment;
    in_seg.last  = in_last_segment;
  end

  sbce_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(in_valid), .wr_ready(in_ready),
    .wr_data(in_seg), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_seg)
  );

  sbce_engine u_eng (
    .clk(clk), .rst_n(rst_n), .box(box_r), .seg_valid(q_valid),
    .seg_ready(q_ready), .seg(q_seg), .res_valid(out_valid),
    .res_ready(out_ready), .res_low(lo), .res_high(hi),
    .res_kept(out_every_segment_kept)
  );

  assign out_low_x  = lo[0];
  assign out_low_y  = lo[1];
  assign out_low_z  = lo[2];
  assign out_high_x = hi[0];
  assign out_high_y = hi[1];
  assign out_high_z = hi[2];

  // The result holds steady while it waits to be taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_low_x))
    else $error("result changed while stalled");
  // A queued transaction is not dropped while the engine is busy.
  a_q_flow: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !q_ready |=> q_valid)
    else $error("queue lost an entry");
endmodule
`default_nettype wire

/* sim/segment_box_clip_extent_tb.sv */
// Testbench for the segment box clip extent block: clips segments against the box and checks each reported extent.
`default_nettype none
module segment_box_clip_extent_tb;
  import sbce_pkg::*;

  localparam longint CoordMax = 64'sd2147483647;
  localparam longint CoordMin = -64'sd2147483648;
  localparam int Span = 100 << 16;
  localparam int Wide = 150 << 16;
  localparam int DrainCycles = 6000;
  localparam int WatchdogLimit = 20000;

  // One segment as the block takes it.
  typedef struct {
    logic signed [31:0] p_start[3];
    logic signed [31:0] p_end[3];
    bit                 first;
    bit                 last;
  } segment_t;

  // One reported extent: low x, y, z then high x, y, z.
  typedef struct {
    logic signed [31:0] bound[6];
    bit                 kept;
  } extent_t;

  // Tracks the clip box and the running extent, and holds the extents still to come.
  class extent_tracker;
    longint box_lo[3];
    longint box_hi[3];
    longint ext_lo[3];
    longint ext_hi[3];
    bit all_kept;
    longint pt[2][3];
    extent_t pending_extents[$];
    int errors;

    function new();
      for (int c = 0; c < 3; c++) begin
        box_lo[c] = CoordMin;
        box_hi[c] = CoordMax;
      end
      clear_extent();
      errors = 0;
    endfunction

    function void clear_extent();
      for (int c = 0; c < 3; c++) begin
        ext_lo[c] = CoordMax;
        ext_hi[c] = CoordMin;
      end
      all_kept = 1'b1;
    endfunction

    function void set_face(logic [2:0] idx, logic signed [31:0] value);
      if (idx[0]) box_hi[idx >> 1] = longint'(value);
      else box_lo[idx >> 1] = longint'(value);
    endfunction

    // Moves endpoint a towards the other one by the ratio n / d, rounded half up.
    function void pull_endpoint(int a, longint n, longint d);
      longint delta;
      logic [127:0] prod;
      logic [127:0] quo;
      logic [127:0] rem;
      for (int c = 0; c < 3; c++) begin
        delta = pt[1-a][c] - pt[a][c];
        prod = 128'(delta < 0 ? -delta : delta) * 128'(n);
        quo = prod / 128'(d);
        rem = prod % 128'(d);
        if (rem >= 128'(d) - rem) quo = quo + 1;
        pt[a][c] = (delta < 0) ? pt[a][c] - longint'(quo) : pt[a][c] + longint'(quo);
      end
    endfunction

    // Returns 0 when the segment lies wholly beyond the face.
    function bit clip_face(int axis, longint face, bit upper);
      longint d1;
      longint d2;
      d1 = upper ? pt[0][axis] - face : face - pt[0][axis];
      d2 = upper ? pt[1][axis] - face : face - pt[1][axis];
      if (d1 > 0) begin
        if (d2 > 0) return 1'b0;
        pull_endpoint(0, d1, d1 - d2);
      end else if (d2 > 0) begin
        pull_endpoint(1, d2, d2 - d1);
      end
      return 1'b1;
    endfunction

    // Clips an accepted segment, widens the extent and queues a report on the last one.
    function void note_segment(segment_t s);
      bit kept;
      extent_t x;
      kept = 1'b1;
      if (s.first) clear_extent();
      for (int c = 0; c < 3; c++) begin
        pt[0][c] = longint'(s.p_start[c]);
        pt[1][c] = longint'(s.p_end[c]);
      end
      for (int c = 0; c < 3 && kept; c++) begin
        kept = clip_face(c, box_lo[c], 1'b0);
        if (kept) kept = clip_face(c, box_hi[c], 1'b1);
      end
      if (!kept) begin
        all_kept = 1'b0;
      end else begin
        for (int c = 0; c < 3; c++) begin
          if (pt[0][c] < ext_lo[c]) ext_lo[c] = pt[0][c];
          if (pt[1][c] < ext_lo[c]) ext_lo[c] = pt[1][c];
          if (pt[0][c] > ext_hi[c]) ext_hi[c] = pt[0][c];
          if (pt[1][c] > ext_hi[c]) ext_hi[c] = pt[1][c];
        end
      end
      if (s.last) begin
        for (int c = 0; c < 3; c++) begin
          x.bound[c] = ext_lo[c][31:0];
          x.bound[3+c] = ext_hi[c][31:0];
        end
        x.kept = all_kept;
        pending_extents = {pending_extents, x};
      end
    endfunction

    // Compares a reported extent with the oldest one waiting.
    function void check_result(extent_t got);
      extent_t want;
      if (pending_extents.size() == 0) begin
        $display("%0t: unexpected extent transaction, low_x %0d", $time, got.bound[0]);
        errors++;
        return;
      end
      want = pending_extents.pop_front();
      for (int f = 0; f < 6; f++) begin
        if (got.bound[f] !== want.bound[f]) begin
          $display("%0t: bound %0d expected %0d actual %0d", $time, f, want.bound[f],
                   got.bound[f]);
          errors++;
        end
      end
      if (got.kept !== want.kept) begin
        $display("%0t: every_segment_kept expected %0b actual %0b", $time, want.kept, got.kept);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic signed [31:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_start_x, in_start_y, in_start_z;
  logic signed [31:0] in_end_x, in_end_y, in_end_z;
  logic in_first_segment, in_last_segment;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_low_x, out_low_y, out_low_z;
  logic signed [31:0] out_high_x, out_high_y, out_high_z;
  logic out_every_segment_kept;

  extent_tracker tracker = new();
  bit quiet = 1'b0;
  int idle_count = 0;

  segment_box_clip_extent dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_start_x(in_start_x), .in_start_y(in_start_y), .in_start_z(in_start_z),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_end_z(in_end_z),
    .in_first_segment(in_first_segment), .in_last_segment(in_last_segment),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_low_x(out_low_x), .out_low_y(out_low_y), .out_low_z(out_low_z),
    .out_high_x(out_high_x), .out_high_y(out_high_y), .out_high_z(out_high_z),
    .out_every_segment_kept(out_every_segment_kept)
  );

  // Clock with a period of two time units.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Result receiver stalls in random bursts, except in the final stretch.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // Each accepted result transaction is checked.
  always @(posedge clk) begin
    extent_t got;
    if (rst_n && out_valid && out_ready) begin
      got.bound[0] = out_low_x;
      got.bound[1] = out_low_y;
      got.bound[2] = out_low_z;
      got.bound[3] = out_high_x;
      got.bound[4] = out_high_y;
      got.bound[5] = out_high_z;
      got.kept = out_every_segment_kept;
      tracker.check_result(got);
    end
  end

  // Watchdog over cycles in which no transaction of any kind is accepted.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic segment_t make_segment(int sx, int sy, int sz, int ex, int ey, int ez,
                                            bit first, bit last);
    segment_t s;
    s.p_start[0] = sx;
    s.p_start[1] = sy;
    s.p_start[2] = sz;
    s.p_end[0] = ex;
    s.p_end[1] = ey;
    s.p_end[2] = ez;
    s.first = first;
    s.last = last;
    return s;
  endfunction

  // Coordinates lean towards the box, with faces, extremes and full random values mixed in.
  function automatic int random_coord(int axis);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? int'(CoordMax) : int'(CoordMin);
      2: return int'(tracker.box_lo[axis]);
      3: return int'(tracker.box_hi[axis]);
      default: return int'($urandom_range(0, 2 * Wide)) - Wide;
    endcase
  endfunction

  task automatic send_segment(segment_t s);
    @(negedge clk);
    in_start_x = s.p_start[0];
    in_start_y = s.p_start[1];
    in_start_z = s.p_start[2];
    in_end_x = s.p_end[0];
    in_end_y = s.p_end[1];
    in_end_z = s.p_end[2];
    in_first_segment = s.first;
    in_last_segment = s.last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.note_segment(s);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk);
    end
  endtask

  // Holds the sender until every extent has come, then lets the engine finish silent segments.
  task automatic drain(int extra);
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending_extents.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_face(logic [2:0] idx, logic signed [31:0] value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_face(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_box(int lx, int hx, int ly, int hy, int lz, int hz);
    drain(DrainCycles);
    write_face(CFG_MIN_X, lx);
    write_face(CFG_MAX_X, hx);
    write_face(CFG_MIN_Y, ly);
    write_face(CFG_MAX_Y, hy);
    write_face(CFG_MIN_Z, lz);
    write_face(CFG_MAX_Z, hz);
  endtask

  // Mostly well-formed runs of segments, with a stray start or a missing end now and then.
  task automatic random_segments(int count, bit pause_midway);
    segment_t s;
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain(0);
      for (int c = 0; c < 3; c++) begin
        s.p_start[c] = random_coord(c);
        s.p_end[c] = random_coord(c);
      end
      s.first = ($urandom_range(0, 5) == 0);
      s.last = ($urandom_range(0, 4) == 0);
      send_segment(s);
    end
  endtask

  task automatic random_box();
    int a;
    int b;
    int lo[3];
    int hi[3];
    for (int c = 0; c < 3; c++) begin
      a = int'($urandom_range(0, 2 * Wide)) - Wide;
      b = int'($urandom_range(0, 2 * Wide)) - Wide;
      lo[c] = (a < b) ? a : b;
      hi[c] = (a < b) ? b : a;
    end
    set_box(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_start_x = '0;
    in_start_y = '0;
    in_start_z = '0;
    in_end_x = '0;
    in_end_y = '0;
    in_end_z = '0;
    in_first_segment = 1'b0;
    in_last_segment = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset box spans everything: extremes pass untouched; the first run has no start flag.
    send_segment(make_segment(int'(CoordMin), int'(CoordMin), int'(CoordMin),
                              int'(CoordMax), int'(CoordMax), int'(CoordMax), 0, 0));
    send_segment(make_segment(0, -1, 1, 0, -1, 1, 0, 1));
    send_segment(make_segment(int'(CoordMax), 5, int'(CoordMin), -7, int'(CoordMax), 0, 1, 1));

    // Box of plus and minus one hundred on each axis.
    set_box(-Span, Span, -Span, Span, -Span, Span);
    send_segment(make_segment(1, 2, 3, -4, -5, -6, 1, 0));
    // Crossing each face in turn, from either end.
    send_segment(make_segment(-3 * Span, 0, 0, 0, 7, 0, 0, 0));
    send_segment(make_segment(0, 9, 0, 3 * Span, -Span / 3, 11, 0, 0));
    send_segment(make_segment(5, -2 * Span, 0, 0, Span / 2, 3, 0, 0));
    send_segment(make_segment(-Span / 7, Span / 5, 0, 13, 5 * Span, -1, 0, 0));
    send_segment(make_segment(3, 1, -Span * 4, -3, 1, Span / 3, 0, 0));
    send_segment(make_segment(0, 0, 1, 17, 19, Span * 9 / 4, 0, 1));
    // Diagonal through the box, crossing every face.
    send_segment(make_segment(-3 * Span, -2 * Span, -5 * Span, 4 * Span, 3 * Span, 2 * Span, 1, 1));
    // Endpoints lying exactly on faces are kept.
    send_segment(make_segment(-Span, -Span, -Span, Span, Span, Span, 1, 1));
    // Wholly outside single faces, then a run whose every segment is dropped.
    send_segment(make_segment(-2 * Span, 0, 0, -Span - 1, 0, 0, 1, 0));
    send_segment(make_segment(0, Span + 1, 0, 0, 3 * Span, 0, 0, 1));
    send_segment(make_segment(0, 0, -4 * Span, 0, 0, -Span - 1, 1, 1));
    // Run with no start flag carries on from the previous one.
    send_segment(make_segment(2, 2, 2, 3, 3, 3, 0, 1));

    // Inverted box drops everything.
    set_box(Span, -Span, Span, -Span, Span, -Span);
    send_segment(make_segment(0, 0, 0, 1, 1, 1, 1, 0));
    random_segments(80, 1'b0);
    send_segment(make_segment(0, 0, 0, 0, 0, 0, 0, 1));

    set_box(-Span, Span, -Span, Span, -Span, Span);
    random_segments(350, 1'b1);

    random_box();
    random_segments(300, 1'b0);

    // Degenerate box of a single point.
    set_box(0, 0, Span, Span, -Span, -Span);
    random_segments(120, 1'b0);

    // Extreme register values written explicitly.
    set_box(int'(CoordMin), int'(CoordMax), int'(CoordMin), int'(CoordMax),
            int'(CoordMin), int'(CoordMax));
    random_segments(150, 1'b0);

    random_box();
    random_segments(300, 1'b0);
    quiet = 1'b1;
    random_segments(200, 1'b0);
    send_segment(make_segment(0, 0, 0, 1, 1, 1, 0, 1));

    drain(DrainCycles);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* segment_box_clip_extent.f */
hdl/sbce_pkg.sv
hdl/sbce_fifo.sv
hdl/sbce_div.sv
hdl/sbce_engine.sv
hdl/segment_box_clip_extent.sv
sim/segment_box_clip_extent_tb.sv
